// ----- hw/rtl/allm_pkg.sv -----
// shared types and constants for the linked list manager
`default_nettype none

package allm_pkg;

   localparam int CELL_COUNT_DEF = 256;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int ACTION_W  = 4;
   localparam int LOC_W     = 8;
   localparam int DATA_IO_W = 32;
   localparam int INDEX_W   = 8;
   localparam int STATUS_W  = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INS_BACK   = 4'd0,
      ACT_INS_FRONT  = 4'd1,
      ACT_INS_AFTER  = 4'd2,
      ACT_INS_BEFORE = 4'd3,
      ACT_DELETE     = 4'd4,
      ACT_DEL_AFTER  = 4'd5,
      ACT_DEL_BEFORE = 4'd6,
      ACT_POP_FRONT  = 4'd7,
      ACT_POP_BACK   = 4'd8,
      ACT_READ       = 4'd9
   } allm_action_type;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

   typedef struct packed {
      logic next_we;
      logic prev_we;
      logic live_we;
      logic data_we;
   } allm_wen_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [INDEX_W-1:0]   cell_index;
      logic [DATA_IO_W-1:0] data_out;
      logic [INDEX_W-1:0]   head_index;
      logic [INDEX_W-1:0]   tail_index;
      logic [INDEX_W-1:0]   entry_count;
   } allm_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/allm_cell_store.sv -----
// cell store memories: next links, prev links, live flags and payloads
`default_nettype none

module allm_cell_store
   import allm_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int IW = $clog2(CELL_COUNT)
) (
   input  wire logic                  clock,
   input  wire logic [IW-1:0]         rd_addr,
   input  wire allm_wen_type          wen,
   input  wire logic [IW-1:0]         next_waddr,
   input  wire logic [IW-1:0]         next_wdata,
   input  wire logic [IW-1:0]         prev_waddr,
   input  wire logic [IW-1:0]         prev_wdata,
   input  wire logic [IW-1:0]         cell_waddr,
   input  wire logic                  live_wdata,
   input  wire logic [DATA_WIDTH-1:0] data_wdata,
   output logic      [IW-1:0]         next_rd,
   output logic      [IW-1:0]         prev_rd,
   output logic                       live_rd,
   output logic      [DATA_WIDTH-1:0] data_rd
);

   logic [IW-1:0]         next_link_ff [CELL_COUNT];
   logic [IW-1:0]         prev_link_ff [CELL_COUNT];
   logic                  cell_live_ff [CELL_COUNT];
   logic [DATA_WIDTH-1:0] payload_ff   [CELL_COUNT];

   always_ff @(posedge clock) begin
      if (wen.next_we) begin
         next_link_ff[next_waddr] <= next_wdata;
      end
      next_rd <= next_link_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wen.prev_we) begin
         prev_link_ff[prev_waddr] <= prev_wdata;
      end
      prev_rd <= prev_link_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wen.live_we) begin
         cell_live_ff[cell_waddr] <= live_wdata;
      end
      live_rd <= cell_live_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wen.data_we) begin
         payload_ff[cell_waddr] <= data_wdata;
      end
      data_rd <= payload_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/allm_seq.sv -----
// action sequencer: list registers and read-modify-write steps on the cell store
`default_nettype none

module allm_seq
   import allm_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int IW = $clog2(CELL_COUNT)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [ACTION_W-1:0]   req_action,
   input  wire logic [LOC_W-1:0]      req_location,
   input  wire logic [DATA_IO_W-1:0]  req_data_in,
   output logic                       done,
   input  wire logic                  taken,
   output allm_rsp_type               result,
   output logic      [IW-1:0]         rd_addr,
   output allm_wen_type               wen,
   output logic      [IW-1:0]         next_waddr,
   output logic      [IW-1:0]         next_wdata,
   output logic      [IW-1:0]         prev_waddr,
   output logic      [IW-1:0]         prev_wdata,
   output logic      [IW-1:0]         cell_waddr,
   output logic                       live_wdata,
   output logic      [DATA_WIDTH-1:0] data_wdata,
   input  wire logic [IW-1:0]         next_rd,
   input  wire logic [IW-1:0]         prev_rd,
   input  wire logic                  live_rd,
   input  wire logic [DATA_WIDTH-1:0] data_rd
);

   localparam int LW = (IW > LOC_W) ? IW : LOC_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_EVAL2,
      S_TAKE,
      S_LINK,
      S_UNLINK1,
      S_UNLINK2,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [ACTION_W-1:0]   act_ff, act_in;
   logic [IW-1:0]         anc_ff, anc_in;
   logic                  anc_ok_ff, anc_ok_in;
   logic [DATA_WIDTH-1:0] din_ff, din_in;
   logic [IW-1:0]         nb_ff, nb_in;
   logic [IW-1:0]         cell_ff, cell_in;
   logic [IW-1:0]         prev_t_ff, prev_t_in;
   logic [IW-1:0]         next_t_ff, next_t_in;
   logic [DATA_WIDTH-1:0] dat_t_ff, dat_t_in;
   logic [STATUS_W-1:0]   st_ff, st_in;
   logic [IW-1:0]         res_cell_ff, res_cell_in;
   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic [IW-1:0]         first_ff, first_in;
   logic [IW-1:0]         last_ff, last_in;
   logic [IW-1:0]         free_ff, free_in;
   logic [IW-1:0]         count_ff, count_in;
   logic [IW:0]           fresh_ff, fresh_in;

   logic [LW-1:0] loc_ext;
   logic          loc_ok;
   logic [IW-1:0] req_anc;
   logic          req_anc_ok;
   logic          live_a;
   logic          ins_empty;
   logic          ins_after;
   logic          c_fresh;
   logic [IW:0]   c_plus;

   assign loc_ext = LW'(req_location);
   assign loc_ok  = (loc_ext != '0) && ({1'b0, loc_ext} < (LW + 1)'(CELL_COUNT));

   always_comb begin
      unique case (req_action) inside
         ACT_INS_BACK, ACT_POP_BACK: begin
            req_anc    = last_ff;
            req_anc_ok = (last_ff != '0);
         end
         ACT_INS_FRONT, ACT_POP_FRONT: begin
            req_anc    = first_ff;
            req_anc_ok = (first_ff != '0);
         end
         ACT_INS_AFTER, ACT_INS_BEFORE, ACT_DELETE, ACT_DEL_AFTER, ACT_DEL_BEFORE,
         ACT_READ: begin
            req_anc    = loc_ext[IW-1:0];
            req_anc_ok = loc_ok;
         end
         default: begin
            req_anc    = '0;
            req_anc_ok = 1'b0;
         end
      endcase
   end

   // cells at or above the fill mark were never touched since reset
   assign live_a    = anc_ok_ff && ({1'b0, anc_ff} < fresh_ff) && live_rd;
   assign ins_empty = ((act_ff == ACT_INS_BACK) || (act_ff == ACT_INS_FRONT)) &&
                      (first_ff == '0);
   assign ins_after = (act_ff == ACT_INS_BACK) || (act_ff == ACT_INS_AFTER);
   assign c_fresh   = ({1'b0, cell_ff} == fresh_ff);
   assign c_plus    = {1'b0, cell_ff} + (IW + 1)'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign done      = (state_ff == S_DONE);

   always_comb begin
      result.status      = st_ff;
      result.cell_index  = INDEX_W'(res_cell_ff);
      result.data_out    = DATA_IO_W'(res_data_ff);
      result.head_index  = INDEX_W'(first_ff);
      result.tail_index  = INDEX_W'(last_ff);
      result.entry_count = INDEX_W'(count_ff);
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      anc_in      = anc_ff;
      anc_ok_in   = anc_ok_ff;
      din_in      = din_ff;
      nb_in       = nb_ff;
      cell_in     = cell_ff;
      prev_t_in   = prev_t_ff;
      next_t_in   = next_t_ff;
      dat_t_in    = dat_t_ff;
      st_in       = st_ff;
      res_cell_in = res_cell_ff;
      res_data_in = res_data_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      fresh_in    = fresh_ff;
      rd_addr     = '0;
      wen         = '0;
      next_waddr  = '0;
      next_wdata  = '0;
      prev_waddr  = '0;
      prev_wdata  = '0;
      cell_waddr  = '0;
      live_wdata  = 1'b0;
      data_wdata  = din_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = req_anc;
            if (req_valid) begin
               act_in    = req_action;
               anc_in    = req_anc;
               anc_ok_in = req_anc_ok;
               din_in    = DATA_WIDTH'(req_data_in);
               state_in  = S_EVAL;
            end
         end

         S_EVAL: begin
            st_in       = ST_OK;
            res_cell_in = '0;
            res_data_in = '0;
            state_in    = S_DONE;
            case (act_ff) inside
               ACT_INS_BACK, ACT_INS_FRONT, ACT_INS_AFTER, ACT_INS_BEFORE: begin
                  if (!live_a && !ins_empty) begin
                     st_in = ST_BAD;
                  end else if (free_ff == '0) begin
                     st_in = ST_FULL;
                  end else begin
                     rd_addr  = free_ff;
                     cell_in  = free_ff;
                     nb_in    = ins_after ? next_rd : prev_rd;
                     state_in = S_TAKE;
                  end
               end
               ACT_DELETE, ACT_POP_FRONT, ACT_POP_BACK: begin
                  if (!live_a) begin
                     st_in = ST_BAD;
                  end else begin
                     cell_in   = anc_ff;
                     prev_t_in = prev_rd;
                     next_t_in = next_rd;
                     dat_t_in  = data_rd;
                     state_in  = S_UNLINK1;
                  end
               end
               ACT_DEL_AFTER: begin
                  if (!live_a) begin
                     st_in = ST_BAD;
                  end else if ((anc_ff == last_ff) || (next_rd == '0)) begin
                     st_in = ST_NONE;
                  end else begin
                     rd_addr  = next_rd;
                     cell_in  = next_rd;
                     state_in = S_EVAL2;
                  end
               end
               ACT_DEL_BEFORE: begin
                  if (!live_a) begin
                     st_in = ST_BAD;
                  end else if ((anc_ff == first_ff) || (prev_rd == '0)) begin
                     st_in = ST_NONE;
                  end else begin
                     rd_addr  = prev_rd;
                     cell_in  = prev_rd;
                     state_in = S_EVAL2;
                  end
               end
               ACT_READ: begin
                  if (!live_a) begin
                     st_in = ST_BAD;
                  end else begin
                     res_cell_in = anc_ff;
                     res_data_in = data_rd;
                  end
               end
               default: begin
               end
            endcase
         end

         S_EVAL2: begin
            prev_t_in = prev_rd;
            next_t_in = next_rd;
            dat_t_in  = data_rd;
            state_in  = S_UNLINK1;
         end

         S_UNLINK1: begin
            wen.next_we = 1'b1;
            next_waddr  = cell_ff;
            next_wdata  = free_ff;
            wen.prev_we = 1'b1;
            prev_waddr  = cell_ff;
            prev_wdata  = '0;
            wen.live_we = 1'b1;
            cell_waddr  = cell_ff;
            live_wdata  = 1'b0;
            free_in     = cell_ff;
            if (last_ff == cell_ff) begin
               last_in = prev_t_ff;
            end
            if (first_ff == cell_ff) begin
               first_in = next_t_ff;
            end
            count_in    = count_ff - IW'(1);
            st_in       = ST_OK;
            res_cell_in = cell_ff;
            res_data_in = dat_t_ff;
            state_in    = S_UNLINK2;
         end

         S_UNLINK2: begin
            if (prev_t_ff != '0) begin
               wen.next_we = 1'b1;
               next_waddr  = prev_t_ff;
               next_wdata  = next_t_ff;
            end
            if (next_t_ff != '0) begin
               wen.prev_we = 1'b1;
               prev_waddr  = next_t_ff;
               prev_wdata  = prev_t_ff;
            end
            state_in = S_DONE;
         end

         S_TAKE: begin
            if (c_fresh) begin
               fresh_in = fresh_ff + (IW + 1)'(1);
               free_in  = (c_plus == (IW + 1)'(CELL_COUNT)) ? '0 : c_plus[IW-1:0];
            end else begin
               free_in = next_rd;
            end
            wen.live_we = 1'b1;
            wen.data_we = 1'b1;
            cell_waddr  = cell_ff;
            live_wdata  = 1'b1;
            wen.next_we = 1'b1;
            next_waddr  = cell_ff;
            wen.prev_we = 1'b1;
            prev_waddr  = cell_ff;
            if (ins_empty) begin
               next_wdata = '0;
               prev_wdata = '0;
               first_in   = cell_ff;
               last_in    = cell_ff;
               state_in   = S_DONE;
            end else begin
               next_wdata = ins_after ? nb_ff : anc_ff;
               prev_wdata = ins_after ? anc_ff : nb_ff;
               if (ins_after && (last_ff == anc_ff)) begin
                  last_in = cell_ff;
               end
               if (!ins_after && (first_ff == anc_ff)) begin
                  first_in = cell_ff;
               end
               state_in = S_LINK;
            end
            count_in    = count_ff + IW'(1);
            st_in       = ST_OK;
            res_cell_in = cell_ff;
            res_data_in = '0;
         end

         S_LINK: begin
            if (ins_after) begin
               wen.next_we = 1'b1;
               next_waddr  = anc_ff;
               next_wdata  = cell_ff;
               if (nb_ff != '0) begin
                  wen.prev_we = 1'b1;
                  prev_waddr  = nb_ff;
                  prev_wdata  = cell_ff;
               end
            end else begin
               wen.prev_we = 1'b1;
               prev_waddr  = anc_ff;
               prev_wdata  = cell_ff;
               if (nb_ff != '0) begin
                  wen.next_we = 1'b1;
                  next_waddr  = nb_ff;
                  next_wdata  = cell_ff;
               end
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (taken) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      anc_ff      <= anc_in;
      anc_ok_ff   <= anc_ok_in;
      din_ff      <= din_in;
      nb_ff       <= nb_in;
      cell_ff     <= cell_in;
      prev_t_ff   <= prev_t_in;
      next_t_ff   <= next_t_in;
      dat_t_ff    <= dat_t_in;
      st_ff       <= st_in;
      res_cell_ff <= res_cell_in;
      res_data_ff <= res_data_in;
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= '0;
         last_ff  <= '0;
         free_ff  <= IW'(1);
         count_ff <= '0;
         fresh_ff <= (IW + 1)'(1);
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         free_ff  <= free_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/array_linked_list_manager_core.sv -----
// linked list manager top level: sequencer, cell store and result register
//
// One request transfer on req_* asks for one list action (insert at back or
// front, insert after or before a cell, delete a cell or its neighbor, pop
// front or back, read a cell). Each request gives exactly one response
// transfer on rsp_* with status, cell index, payload, head, tail and count.
// Requests are handled one at a time; req_stall is high while one is in work.
// A read, an error or an unused code is settled on evaluation; an insert then
// takes a free cell and, unless the list was empty, links its neighbors;
// delete and pop unlink the cell and then its neighbors, and delete after or
// before first reads the neighbor cell. The next request is taken in the cycle
// after the result is loaded. The steps are set by the single read port of the
// cell store and the two link writes that each insert or delete makes.
// The result register holds a response while rsp_stall is high; a finished
// action then waits until the register is free.
// Reset empties the list and makes every cell but cell 0 free; a fill mark
// tracks cells never used since reset, so no clearing pass is needed and
// requests are taken right after reset.
`default_nettype none

module array_linked_list_manager_core
   import allm_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [LOC_W-1:0]     req_location,
   input  wire logic [DATA_IO_W-1:0] req_data_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [STATUS_W-1:0]  rsp_status,
   output logic      [INDEX_W-1:0]   rsp_cell_index,
   output logic      [DATA_IO_W-1:0] rsp_data_out,
   output logic      [INDEX_W-1:0]   rsp_head_index,
   output logic      [INDEX_W-1:0]   rsp_tail_index,
   output logic      [INDEX_W-1:0]   rsp_entry_count
);

   localparam int IW = $clog2(CELL_COUNT);

   logic                  done;
   logic                  taken;
   allm_rsp_type          result;
   logic [IW-1:0]         rd_addr;
   allm_wen_type          wen;
   logic [IW-1:0]         next_waddr;
   logic [IW-1:0]         next_wdata;
   logic [IW-1:0]         prev_waddr;
   logic [IW-1:0]         prev_wdata;
   logic [IW-1:0]         cell_waddr;
   logic                  live_wdata;
   logic [DATA_WIDTH-1:0] data_wdata;
   logic [IW-1:0]         next_rd;
   logic [IW-1:0]         prev_rd;
   logic                  live_rd;
   logic [DATA_WIDTH-1:0] data_rd;

   logic                  rsp_valid_ff, rsp_valid_in;
   allm_rsp_type          rsp_ff, rsp_in;

   allm_seq #(
      .CELL_COUNT (CELL_COUNT),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_location (req_location),
      .req_data_in  (req_data_in),
      .done         (done),
      .taken        (taken),
      .result       (result),
      .rd_addr      (rd_addr),
      .wen          (wen),
      .next_waddr   (next_waddr),
      .next_wdata   (next_wdata),
      .prev_waddr   (prev_waddr),
      .prev_wdata   (prev_wdata),
      .cell_waddr   (cell_waddr),
      .live_wdata   (live_wdata),
      .data_wdata   (data_wdata),
      .next_rd      (next_rd),
      .prev_rd      (prev_rd),
      .live_rd      (live_rd),
      .data_rd      (data_rd)
   );

   allm_cell_store #(
      .CELL_COUNT (CELL_COUNT),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .wen        (wen),
      .next_waddr (next_waddr),
      .next_wdata (next_wdata),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata),
      .cell_waddr (cell_waddr),
      .live_wdata (live_wdata),
      .data_wdata (data_wdata),
      .next_rd    (next_rd),
      .prev_rd    (prev_rd),
      .live_rd    (live_rd),
      .data_rd    (data_rd)
   );

   // result register is free when empty or when its transfer completes now
   assign taken        = done && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = taken || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = taken ? result : rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_cell_index  = rsp_ff.cell_index;
   assign rsp_data_out    = rsp_ff.data_out;
   assign rsp_head_index  = rsp_ff.head_index;
   assign rsp_tail_index  = rsp_ff.tail_index;
   assign rsp_entry_count = rsp_ff.entry_count;

endmodule

`default_nettype wire

// ----- dv/tb_array_linked_list_manager_core.sv -----
// self-checking testbench for the array linked list manager core
module tb_array_linked_list_manager_core;
   timeunit 1ns;
   timeprecision 1ps;
   import allm_pkg::*;

   localparam int NUM_CELLS     = CELL_COUNT_DEF;
   localparam int ACTION_LAST   = (1 << ACTION_W) - 1;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_SHOWN     = 10;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [ACTION_W-1:0]  req_action   = '0;
   logic [LOC_W-1:0]     req_location = '0;
   logic [DATA_IO_W-1:0] req_data_in  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [INDEX_W-1:0]   rsp_cell_index;
   logic [DATA_IO_W-1:0] rsp_data_out;
   logic [INDEX_W-1:0]   rsp_head_index;
   logic [INDEX_W-1:0]   rsp_tail_index;
   logic [INDEX_W-1:0]   rsp_entry_count;

   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int quiet_cycles   = 0;
   int mismatch_count = 0;
   int peak_size      = 0;
   int action_seen [ACTION_LAST+1];
   int status_seen [1 << STATUS_W];

   // list image: links, live flags, payloads, ends and free chain
   logic [INDEX_W-1:0]   fwd_link  [NUM_CELLS];
   logic [INDEX_W-1:0]   back_link [NUM_CELLS];
   bit                   cell_on   [NUM_CELLS];
   logic [DATA_IO_W-1:0] cell_word [NUM_CELLS];
   logic [INDEX_W-1:0]   list_first;
   logic [INDEX_W-1:0]   list_last;
   logic [INDEX_W-1:0]   free_top;
   int                   list_size;
   allm_rsp_type         due_results [$];

   array_linked_list_manager_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_location   (req_location),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_cell_index (rsp_cell_index),
      .rsp_data_out   (rsp_data_out),
      .rsp_head_index (rsp_head_index),
      .rsp_tail_index (rsp_tail_index),
      .rsp_entry_count(rsp_entry_count)
   );

   always #1 clock = ~clock;

   function automatic bit cell_in_list(logic [INDEX_W-1:0] c);
      return c != '0 && int'(c) < NUM_CELLS && cell_on[c];
   endfunction

   function automatic logic [INDEX_W-1:0] grab_cell(logic [DATA_IO_W-1:0] d);
      logic [INDEX_W-1:0] c;
      c = free_top;
      if (c == '0) return '0;
      free_top     = fwd_link[c];
      cell_word[c] = d;
      cell_on[c]   = 1'b1;
      list_size++;
      return c;
   endfunction

   function automatic logic [STATUS_W-1:0] link_first(input logic [DATA_IO_W-1:0] d,
                                                      output logic [INDEX_W-1:0] slot);
      logic [INDEX_W-1:0] c;
      c    = grab_cell(d);
      slot = c;
      if (c == '0) return ST_FULL;
      fwd_link[c]  = '0;
      back_link[c] = '0;
      list_first   = c;
      list_last    = c;
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] link_after(input logic [INDEX_W-1:0] loc,
                                                      input logic [DATA_IO_W-1:0] d,
                                                      output logic [INDEX_W-1:0] slot);
      logic [INDEX_W-1:0] c;
      logic [INDEX_W-1:0] n;
      slot = '0;
      if (!cell_in_list(loc)) return ST_BAD;
      c = grab_cell(d);
      if (c == '0) return ST_FULL;
      n            = fwd_link[loc];
      back_link[c] = loc;
      fwd_link[c]  = n;
      if (n != '0) back_link[n] = c;
      fwd_link[loc] = c;
      if (list_last == loc) list_last = c;
      slot = c;
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] link_before(input logic [INDEX_W-1:0] loc,
                                                       input logic [DATA_IO_W-1:0] d,
                                                       output logic [INDEX_W-1:0] slot);
      logic [INDEX_W-1:0] c;
      logic [INDEX_W-1:0] p;
      slot = '0;
      if (!cell_in_list(loc)) return ST_BAD;
      c = grab_cell(d);
      if (c == '0) return ST_FULL;
      p            = back_link[loc];
      fwd_link[c]  = loc;
      back_link[c] = p;
      if (p != '0) fwd_link[p] = c;
      back_link[loc] = c;
      if (list_first == loc) list_first = c;
      slot = c;
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] unlink_cell(input logic [INDEX_W-1:0] loc,
                                                       output logic [INDEX_W-1:0] slot,
                                                       output logic [DATA_IO_W-1:0] data);
      logic [INDEX_W-1:0] p;
      logic [INDEX_W-1:0] n;
      slot = '0;
      data = '0;
      if (!cell_in_list(loc)) return ST_BAD;
      p = back_link[loc];
      n = fwd_link[loc];
      if (list_last == loc) list_last = p;
      if (list_first == loc) list_first = n;
      if (p != '0) fwd_link[p] = n;
      if (n != '0) back_link[n] = p;
      fwd_link[loc]  = free_top;
      free_top       = loc;
      back_link[loc] = '0;
      cell_on[loc]   = 1'b0;
      list_size--;
      slot = loc;
      data = cell_word[loc];
      return ST_OK;
   endfunction

   function automatic allm_rsp_type apply_list_action(logic [ACTION_W-1:0] act,
                                                      logic [LOC_W-1:0] loc,
                                                      logic [DATA_IO_W-1:0] din);
      allm_rsp_type         r;
      logic [INDEX_W-1:0]   c;
      logic [DATA_IO_W-1:0] d;
      r = '0;
      c = '0;
      d = '0;
      case (act)
         ACT_INS_BACK: begin
            if (list_first == '0) r.status = link_first(din, c);
            else r.status = link_after(list_last, din, c);
         end
         ACT_INS_FRONT: begin
            if (list_first == '0) r.status = link_first(din, c);
            else r.status = link_before(list_first, din, c);
         end
         ACT_INS_AFTER:  r.status = link_after(loc, din, c);
         ACT_INS_BEFORE: r.status = link_before(loc, din, c);
         ACT_DELETE:     r.status = unlink_cell(loc, c, d);
         ACT_DEL_AFTER: begin
            if (!cell_in_list(loc)) r.status = ST_BAD;
            else if (loc == list_last || fwd_link[loc] == '0) r.status = ST_NONE;
            else r.status = unlink_cell(fwd_link[loc], c, d);
         end
         ACT_DEL_BEFORE: begin
            if (!cell_in_list(loc)) r.status = ST_BAD;
            else if (loc == list_first || back_link[loc] == '0) r.status = ST_NONE;
            else r.status = unlink_cell(back_link[loc], c, d);
         end
         ACT_POP_FRONT: r.status = unlink_cell(list_first, c, d);
         ACT_POP_BACK:  r.status = unlink_cell(list_last, c, d);
         ACT_READ: begin
            if (cell_in_list(loc)) begin
               c = loc;
               d = cell_word[loc];
            end else begin
               r.status = ST_BAD;
            end
         end
         default: ;
      endcase
      if (r.status == ST_OK) begin
         r.cell_index = c;
         r.data_out   = d;
      end
      r.head_index  = list_first;
      r.tail_index  = list_last;
      r.entry_count = INDEX_W'(list_size);
      return r;
   endfunction

   function automatic string rsp_text(allm_rsp_type r);
      return $sformatf("status %0d cell %0d data %08h head %0d tail %0d count %0d",
                       r.status, r.cell_index, r.data_out, r.head_index, r.tail_index,
                       r.entry_count);
   endfunction

   // mostly live cells, sometimes the ends, sometimes any index
   function automatic logic [LOC_W-1:0] pick_location();
      logic [INDEX_W-1:0] live_cells [$];
      int p;
      p = $urandom_range(99);
      if (p < 75 && list_size > 0) begin
         for (int i = 1; i < NUM_CELLS; i++)
            if (cell_on[i]) live_cells.push_back(INDEX_W'(i));
         return live_cells[$urandom_range(live_cells.size() - 1)];
      end
      if (p < 87) return $urandom_range(1) ? list_first : list_last;
      return LOC_W'($urandom_range((1 << LOC_W) - 1));
   endfunction

   task automatic send_item(logic [ACTION_W-1:0] act, logic [LOC_W-1:0] loc,
                            logic [DATA_IO_W-1:0] din);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_location <= loc;
      req_data_in  <= din;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_results.push_back(apply_list_action(act, loc, din));
      action_seen[act]++;
      if (list_size > peak_size) peak_size = list_size;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(int ins_pct);
      int                  r;
      logic [ACTION_W-1:0] act;
      r = $urandom_range(99);
      if (r < ins_pct) act = ACTION_W'($urandom_range(ACT_INS_BEFORE, ACT_INS_BACK));
      else if (r < 96) act = ACTION_W'($urandom_range(ACT_READ, ACT_DELETE));
      else act = ACTION_W'($urandom_range(ACTION_LAST, ACT_READ + 1));
      if ($urandom_range(49) == 0) wait_drained();
      send_item(act, pick_location(), $urandom());
   endtask

   task automatic test_empty_list_errors();
      req_idle_pct = 12;
      rsp_idle_pct = 49;
      send_item(ACT_POP_FRONT, '0, '0);
      send_item(ACT_POP_BACK, LOC_W'(1), '1);
      send_item(ACT_INS_AFTER, LOC_W'(1), 32'h1234_5678);
      send_item(ACT_INS_BEFORE, '1, 32'h8765_4321);
      send_item(ACT_DELETE, '0, '0);
      send_item(ACT_DEL_AFTER, LOC_W'(1), '0);
      send_item(ACT_DEL_BEFORE, '1, '0);
      send_item(ACT_READ, '0, '0);
      send_item(ACTION_W'(ACTION_LAST), '1, '1);
   endtask

   task automatic test_link_edits();
      send_item(ACT_INS_BACK, '0, '1);
      send_item(ACT_INS_FRONT, '0, '0);
      send_item(ACT_INS_AFTER, list_first, 32'hA5A5_A5A5);
      send_item(ACT_INS_BEFORE, list_last, 32'h5A5A_5A5A);
      send_item(ACT_READ, list_last, '0);
      send_item(ACT_READ, '1, '0);
      // no neighbor at either end
      send_item(ACT_DEL_AFTER, list_last, '0);
      send_item(ACT_DEL_BEFORE, list_first, '0);
      send_item(ACT_DEL_AFTER, list_first, '0);
      send_item(ACT_DEL_BEFORE, list_last, '0);
      send_item(ACT_DELETE, list_first, '0);
      send_item(ACTION_W'(ACT_READ + 1), list_last, '1);
      wait_drained();
      send_item(ACT_POP_BACK, '0, '0);
      // empty list insert takes the most recently freed cell
      send_item(ACT_INS_FRONT, '0, 32'h0000_0001);
      send_item(ACT_INS_BACK, '0, 32'h8000_0000);
      send_item(ACT_POP_FRONT, '0, '0);
      send_item(ACT_READ, list_first, '0);
   endtask

   task automatic test_random_traffic(int req_pct, int rsp_pct, int count);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) send_random(50);
   endtask

   task automatic test_fill_to_capacity();
      int guard;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      guard = 0;
      while (list_size < NUM_CELLS - 1 && guard < 1000) begin
         send_random(92);
         guard++;
      end
      repeat (6)
         send_item(ACTION_W'($urandom_range(ACT_INS_BEFORE, ACT_INS_BACK)), pick_location(),
                   $urandom());
      repeat (100) send_random(12);
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("no transfer for %0d cycles, %0d results still due", QUIET_LIMIT,
               due_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      allm_rsp_type seen;
      allm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_status, rsp_cell_index, rsp_data_out, rsp_head_index, rsp_tail_index,
                 rsp_entry_count};
         status_seen[rsp_status]++;
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("unexpected result transfer: %s", rsp_text(seen));
         end else begin
            want = due_results.pop_front();
            if (seen.status !== want.status || seen.cell_index !== want.cell_index ||
                seen.data_out !== want.data_out || seen.head_index !== want.head_index ||
                seen.tail_index !== want.tail_index || seen.entry_count !== want.entry_count)
            begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("mismatch: expected %s, got %s", rsp_text(want), rsp_text(seen));
            end
         end
      end
   end

   initial begin
      int unused_seen;
      int total_seen;
      for (int i = 0; i < NUM_CELLS; i++) begin
         fwd_link[i]  = (i != 0 && i + 1 < NUM_CELLS) ? INDEX_W'(i + 1) : '0;
         back_link[i] = '0;
         cell_on[i]   = 1'b0;
         cell_word[i] = '0;
      end
      list_first = '0;
      list_last  = '0;
      free_top   = INDEX_W'(1);
      list_size  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list_errors();
      test_link_edits();
      test_random_traffic(12, 49, 90);
      test_random_traffic(49, 12, 90);
      test_fill_to_capacity();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      unused_seen = 0;
      total_seen  = 0;
      for (int a = 0; a <= ACTION_LAST; a++) begin
         total_seen += action_seen[a];
         if (a > ACT_READ) unused_seen += action_seen[a];
      end
      $display("covered %0d requests over all actions (%0d unused codes), peak list size %0d",
               total_seen, unused_seen, peak_size);
      $display("status ok/bad/full/no-neighbor seen %0d/%0d/%0d/%0d times, %0d mismatches",
               status_seen[ST_OK], status_seen[ST_BAD], status_seen[ST_FULL],
               status_seen[ST_NONE], mismatch_count);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/allm_pkg.sv
hw/rtl/allm_cell_store.sv
hw/rtl/allm_seq.sv
hw/rtl/array_linked_list_manager_core.sv
dv/tb_array_linked_list_manager_core.sv
